// ----- hw/rtl/ctw_pkg.sv -----
// Shared types and constants for the text-mode console writer.
// Used by the controller, the datapath and the top level; no dependencies.
package ctw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CODE_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // character codes
  localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
  localparam logic [CODE_W-1:0] CODE_FIRST = 8'd32;
  localparam logic [CODE_W-1:0] CODE_LAST  = 8'd126;

  // item functions
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COL_MIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_MAX   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_MIN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_MAX   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTRIBUTE = 3'd4;

  // register reset values
  localparam logic [COL_W-1:0]  COL_MIN_RST   = 7'd0;
  localparam logic [COL_W-1:0]  COL_MAX_RST   = 7'd80;
  localparam logic [ROW_W-1:0]  ROW_MIN_RST   = 5'd0;
  localparam logic [ROW_W-1:0]  ROW_MAX_RST   = 5'd25;
  localparam logic [ATTR_W-1:0] ATTRIBUTE_RST = 8'd31;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the input item
    logic clr_step;    // zero one cell of the clearing pass
    logic put_apply;   // update cursor, write the character, arm the scroll walk
    logic rd_issue;    // read the cell named by a read item
    logic rd_finish;   // take the read data into the result
    logic cp_read;     // read the source cell one row down
    logic cp_write;    // write it one row up, advance column
    logic next_row;    // step the copy walk to the next row
    logic fill_init;   // start the blank fill of the bottom row
    logic fill_write;  // write one blank cell, advance column
  } ctw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic func;
    logic scroll;
    logic row_max_zero;
    logic col_done;
    logic rows_done;
  } ctw_status_t;

endpackage

// ----- hw/rtl/text_mode_console_writer.sv -----
// Character-cell console writer: controller plus datapath with a ROWS x COLUMNS
// cell store. Depends on ctw_pkg, ctw_ctrl, ctw_datapath (and ctw_ram below it).
//
// Usage:
//   Raise start with func/char_code/read_col/read_row; the item is taken at a
//   clock edge where start is high and busy is low. func 0 puts a character at
//   the cursor (CR, LF, printable 32..126), func 1 reads one cell.
//   Each item gives one result: done is high for exactly one cycle with
//   cell_data, cursor_col, cursor_row and scrolled valid in that cycle. The
//   receiver cannot stall; the result is taken in that cycle.
//   Sequence: a put without scroll passes DECODE back to IDLE; a read passes
//   DECODE and RDOUT (registered read of the store); done is high in the cycle
//   whose closing edge can take the next item. A put that scrolls (row_max not
//   zero) copies the window up a row, cell by cell, then blanks the bottom row.
//   Reset: rst (synchronous) restores the registers and cursor, then the block
//   zeroes the store one cell per cycle, with busy high.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
//   user must issue them only while the block is idle, which it does not enforce.
module text_mode_console_writer
  import ctw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func,
  input  logic [CODE_W-1:0]      char_code,
  input  logic [COL_W-1:0]       read_col,
  input  logic [ROW_W-1:0]       read_row,
  output logic                   done,
  output logic [CELL_W-1:0]      cell_data,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   scrolled,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctw_cmd_t    cmd;
  ctw_status_t status;

  ctw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .status(status),
    .cmd   (cmd)
  );

  ctw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .char_code (char_code),
    .read_col  (read_col),
    .read_row  (read_row),
    .cmd       (cmd),
    .status    (status),
    .cell_data (cell_data),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .scrolled  (scrolled)
  );

endmodule

// ----- hw/rtl/ctw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ctw_ctrl.sv -----
// Controller for the console writer: sequences clearing, puts, reads and the
// scroll walk. Depends on ctw_pkg.
module ctw_ctrl
  import ctw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  ctw_status_t status,
  output ctw_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RDOUT,
    S_CP_ROW,
    S_CP_WRITE,
    S_FILL
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: cmd.load = start;
      S_DECODE: begin
        if (status.func == FUNC_READ) begin
          cmd.rd_issue = 1'b1;
        end else begin
          cmd.put_apply = 1'b1;
        end
      end
      S_RDOUT: cmd.rd_finish = 1'b1;
      S_CP_ROW: begin
        if (status.rows_done) begin
          cmd.fill_init = 1'b1;
        end else if (status.col_done) begin
          cmd.next_row = 1'b1;
        end else begin
          cmd.cp_read = 1'b1;
        end
      end
      S_CP_WRITE: cmd.cp_write = 1'b1;
      S_FILL: cmd.fill_write = !status.col_done;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (status.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (status.func == FUNC_READ) begin
            state <= S_RDOUT;
          end else if (status.scroll && !status.row_max_zero) begin
            state <= S_CP_ROW;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RDOUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CP_ROW: begin
          if (status.rows_done) begin
            state <= S_FILL;
          end else if (!status.col_done) begin
            state <= S_CP_WRITE;
          end
        end
        S_CP_WRITE: state <= S_CP_ROW;
        S_FILL: begin
          if (status.col_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ctw_datapath.sv -----
// Datapath for the console writer: configuration registers, cursor, cell
// store, scroll walk counters and result registers. Depends on ctw_pkg, ctw_ram.
module ctw_datapath
  import ctw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   func,
  input  logic [CODE_W-1:0]      char_code,
  input  logic [COL_W-1:0]       read_col,
  input  logic [ROW_W-1:0]       read_row,
  input  ctw_cmd_t               cmd,
  output ctw_status_t            status,
  output logic [CELL_W-1:0]      cell_data,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   scrolled
);

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [COL_W-1:0]  col_min, col_max;
  logic [ROW_W-1:0]  row_min, row_max;
  logic [ATTR_W-1:0] attribute;

  // cursor and clearing pointer
  logic [COL_W-1:0]  cur_x;
  logic [ROW_W-1:0]  cur_y;
  logic [ADDR_W-1:0] clr_ptr;

  // latched item and walk state
  logic              func_q;
  logic [CODE_W-1:0] code_q;
  logic [COL_W-1:0]  rcol_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  sx;
  logic [ROW_W-1:0]  sy;
  logic              src_ok;

  // put decode
  logic [COL_W:0]    nx;
  logic [ROW_W:0]    ny;
  logic              printable;
  logic              scroll_need;

  // memory ports
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;
  logic [COL_W-1:0]  wcol, rcol_sel;
  logic [ROW_W-1:0]  wrow, rrow_sel;
  logic [ROW_W-1:0]  fill_row;
  logic [ROW_W-1:0]  src_row;

  function automatic logic in_store(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    in_store = (32'(c) < COLUMNS) && (32'(r) < ROWS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] r);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
  endfunction

  assign printable = (code_q >= CODE_FIRST) && (code_q <= CODE_LAST);
  assign fill_row  = row_max - ROW_W'(1);
  assign src_row   = sy + ROW_W'(1);

  always_comb begin
    nx = {1'b0, cur_x};
    ny = {1'b0, cur_y};
    if (code_q == CODE_CR) begin
      nx = {1'b0, col_min};
    end else if (code_q == CODE_LF) begin
      nx = {1'b0, col_min};
      ny = ny + (ROW_W+1)'(1);
    end else if (printable) begin
      nx = nx + (COL_W+1)'(1);
    end
    // wrap to the next row at the right edge of the window
    if (nx >= {1'b0, col_max}) begin
      nx = {1'b0, col_min};
      ny = ny + (ROW_W+1)'(1);
    end
    scroll_need = (ny >= {1'b0, row_max});
  end

  // write port selection
  always_comb begin
    wcol  = sx;
    wrow  = sy;
    wdata = '0;
    we    = 1'b0;
    if (cmd.put_apply) begin
      wcol  = cur_x;
      wrow  = cur_y;
      wdata = {attribute, code_q};
      we    = printable && in_store(cur_x, cur_y);
    end else if (cmd.cp_write) begin
      wdata = src_ok ? rdata : '0;
      we    = in_store(sx, sy);
    end else if (cmd.fill_write) begin
      wrow  = fill_row;
      wdata = {attribute, CODE_SPACE};
      we    = in_store(sx, fill_row);
    end
    waddr = cell_addr(wcol, wrow);
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_ptr;
      wdata = '0;
    end
  end

  // read port selection
  always_comb begin
    if (cmd.cp_read) begin
      rcol_sel = sx;
      rrow_sel = src_row;
    end else begin
      rcol_sel = rcol_q;
      rrow_sel = rrow_q;
    end
    re    = cmd.cp_read || cmd.rd_issue;
    raddr = cell_addr(rcol_sel, rrow_sel);
  end

  ctw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_min   <= COL_MIN_RST;
      col_max   <= COL_MAX_RST;
      row_min   <= ROW_MIN_RST;
      row_max   <= ROW_MAX_RST;
      attribute <= ATTRIBUTE_RST;
      cur_x     <= '0;
      cur_y     <= '0;
      clr_ptr   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COL_MIN:   col_min   <= cfg_data[COL_W-1:0];
          REG_COL_MAX:   col_max   <= cfg_data[COL_W-1:0];
          REG_ROW_MIN:   row_min   <= cfg_data[ROW_W-1:0];
          REG_ROW_MAX:   row_max   <= cfg_data[ROW_W-1:0];
          REG_ATTRIBUTE: attribute <= cfg_data[ATTR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_ptr <= clr_ptr + ADDR_W'(1);
      end
      if (cmd.put_apply) begin
        if (scroll_need) begin
          cur_x <= col_min;
          cur_y <= (row_max != '0) ? fill_row : '0;
        end else begin
          cur_x <= nx[COL_W-1:0];
          cur_y <= ny[ROW_W-1:0];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      code_q <= char_code;
      rcol_q <= read_col;
      rrow_q <= read_row;
    end
    if (cmd.put_apply) begin
      cell_data <= '0;
      scrolled  <= scroll_need;
      sx        <= col_min;
      sy        <= row_min;
    end
    if (cmd.rd_issue) begin
      src_ok <= in_store(rcol_q, rrow_q);
    end
    if (cmd.cp_read) begin
      src_ok <= in_store(sx, src_row);
    end
    if (cmd.rd_finish) begin
      cell_data <= src_ok ? rdata : '0;
      scrolled  <= 1'b0;
    end
    if (cmd.cp_write || cmd.fill_write) begin
      sx <= sx + COL_W'(1);
    end
    if (cmd.next_row) begin
      sx <= col_min;
      sy <= src_row;
    end
    if (cmd.fill_init) begin
      sx <= col_min;
    end
  end

  assign cursor_col = cur_x;
  assign cursor_row = cur_y;

  assign status.clr_last     = (clr_ptr == ADDR_W'(DEPTH - 1));
  assign status.func         = func_q;
  assign status.scroll       = scroll_need;
  assign status.row_max_zero = (row_max == '0);
  assign status.col_done     = (sx >= col_max);
  assign status.rows_done    = ({1'b0, sy} + (ROW_W+1)'(1)) >= {1'b0, row_max};

endmodule
